FILE: hdl/one_wire_bus_master_unit_macros.svh
// Assertion macros shared by the one-wire bus master RTL.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OWBM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OWBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/owbm_pkg.sv
// Shared constants, codes and helper functions of the one-wire bus master.
package owbm_pkg;

   // Field and register widths.
   localparam int LongTickWidth  = 16;
   localparam int ShortTickWidth = 8;
   localparam int ByteWidth      = 8;
   localparam int OpcodeWidth    = 2;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;
   localparam int ReqDataWidth   = 16;
   localparam int ReqUserWidth   = 3;
   localparam int RspDataWidth   = 16;

   // Command codes.
   localparam logic [OpcodeWidth-1:0] OP_RESET = 2'd0;
   localparam logic [OpcodeWidth-1:0] OP_WRITE = 2'd1;
   localparam logic [OpcodeWidth-1:0] OP_READ  = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_RESET_RELEASE = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_POLL_LIMIT    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SHORT_PULSE   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_WRITE_SLOT    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_READ_RECOVER  = 3'd5;

   // Configuration values after reset.
   localparam logic [LongTickWidth-1:0]  RESET_LOW_DEFAULT     = 16'd75;
   localparam logic [LongTickWidth-1:0]  RESET_RELEASE_DEFAULT = 16'd2;
   localparam logic [ShortTickWidth-1:0] POLL_LIMIT_DEFAULT    = 8'd20;
   localparam logic [ShortTickWidth-1:0] SHORT_PULSE_DEFAULT   = 8'd2;
   localparam logic [LongTickWidth-1:0]  WRITE_SLOT_DEFAULT    = 16'd6;
   localparam logic [LongTickWidth-1:0]  READ_RECOVER_DEFAULT  = 16'd5;

   // A zero timing value behaves as one tick.
   function automatic logic [LongTickWidth-1:0] at_least_one_long(
      input logic [LongTickWidth-1:0] value);
      at_least_one_long = (value == '0) ? LongTickWidth'(1) : value;
   endfunction

   function automatic logic [ShortTickWidth-1:0] at_least_one_short(
      input logic [ShortTickWidth-1:0] value);
      at_least_one_short = (value == '0) ? ShortTickWidth'(1) : value;
   endfunction

endpackage

FILE: hdl/one_wire_bus_master_unit.sv
// Top level of the one-wire bus master: tick sequencer with a registered response.
//
// Each request transaction is one time tick of the bus: it carries an optional
// command and the line level sampled in that tick, and it produces exactly one
// response transaction with the line drive and the status of that tick. A new
// request is taken in every cycle as long as the response register is empty or
// is being drained in the same cycle, so the block runs at one tick per clock
// cycle; the single response register is what sets that figure. Commands
// offered while a command is in progress, and opcode 3, are ignored. A reset
// command holds the line low, releases it and then polls for the presence
// pulse (line falling, then rising), flagging a failure when a poll phase
// reaches its limit. A write command sends eight slots, least significant bit
// first; a read command sends eight short pulses and shifts each sampled bit
// in from the top, and the byte appears with done. All timing registers count
// in ticks, and a zero value behaves as one. Configuration is to be written only
// while no command is running; the block itself does not enforce this.
module one_wire_bus_master_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: write_data[7:0], line_level[8], zero fill [15:9].
   input  logic [owbm_pkg::ReqDataWidth-1:0]     req_tdata,
   // tuser: command_valid[0], opcode[2:1].
   input  logic [owbm_pkg::ReqUserWidth-1:0]     req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: drive_low[0], busy_res[1], done_res[2], presence_fail[3],
   // rx_byte[11:4], zero fill [15:12].
   output logic [owbm_pkg::RspDataWidth-1:0]     rsp_tdata,
   // Configuration write port.
   input  logic                                  csr_wen,
   input  logic [owbm_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [owbm_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import owbm_pkg::*;

`include "one_wire_bus_master_unit_macros.svh"

   // Sequencer phase codes.
   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_RST_LOW    = 4'd1;
   localparam logic [3:0] PH_RST_REL    = 4'd2;
   localparam logic [3:0] PH_POLL_FALL  = 4'd3;
   localparam logic [3:0] PH_POLL_RISE  = 4'd4;
   localparam logic [3:0] PH_WR_LOW     = 4'd5;
   localparam logic [3:0] PH_WR_HIGH    = 4'd6;
   localparam logic [3:0] PH_RD_LOW     = 4'd7;
   localparam logic [3:0] PH_RD_SETTLE  = 4'd8;
   localparam logic [3:0] PH_RD_RECOVER = 4'd9;

   // Configuration registers.
   logic [LongTickWidth-1:0]  reset_low_ff;
   logic [LongTickWidth-1:0]  reset_release_ff;
   logic [ShortTickWidth-1:0] poll_limit_ff;
   logic [ShortTickWidth-1:0] short_pulse_ff;
   logic [LongTickWidth-1:0]  write_slot_ff;
   logic [LongTickWidth-1:0]  read_recover_ff;

   // Sequencer state.
   logic [3:0]                phase_ff,  phase_in;
   logic [2:0]                bit_ff,    bit_in;
   logic [LongTickWidth-1:0]  tick_ff,   tick_in;
   logic [ShortTickWidth-1:0] poll_ff,   poll_in;
   logic [ByteWidth-1:0]      shift_ff,  shift_in;
   logic                      fail_ff,   fail_in;

   // Response register.
   logic                      rsp_valid_ff;
   logic [RspDataWidth-1:0]   rsp_data_ff, rsp_data_in;

   // Request fields.
   logic                      cmd_valid;
   logic [OpcodeWidth-1:0]    opcode;
   logic [ByteWidth-1:0]      write_data;
   logic                      line_level;
   logic                      req_accept;

   // Per-tick outputs.
   logic                      drive_low;
   logic                      busy_res;
   logic                      done_res;
   logic                      presence_fail;
   logic [ByteWidth-1:0]      rx_byte;

   // Shared slot lengths.
   logic [LongTickWidth-1:0]  short_len;
   logic [LongTickWidth-1:0]  slot_len;

   assign cmd_valid  = req_tuser[0];
   assign opcode     = req_tuser[2:1];
   assign write_data = req_tdata[ByteWidth-1:0];
   assign line_level = req_tdata[ByteWidth];

   // The response register frees up in the same cycle it is drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign short_len = LongTickWidth'(at_least_one_short(short_pulse_ff));
   assign slot_len  = at_least_one_long(write_slot_ff);

   // One tick of the sequencer: a command start, then the work of the phase
   // that is current after it, all in the same tick.
   always_comb begin
      logic [LongTickWidth-1:0]  tick_dec;
      logic [ShortTickWidth-1:0] poll_inc;

      phase_in      = phase_ff;
      bit_in        = bit_ff;
      tick_in       = tick_ff;
      poll_in       = poll_ff;
      shift_in      = shift_ff;
      fail_in       = fail_ff;
      drive_low     = 1'b0;
      busy_res      = 1'b0;
      done_res      = 1'b0;
      presence_fail = 1'b0;
      rx_byte       = '0;

      if (phase_ff == PH_IDLE && cmd_valid &&
          opcode inside {OP_RESET, OP_WRITE, OP_READ}) begin
         bit_in  = '0;
         poll_in = '0;
         fail_in = 1'b0;
         case (opcode)
            OP_RESET: begin
               phase_in = PH_RST_LOW;
               tick_in  = at_least_one_long(reset_low_ff);
            end
            OP_WRITE: begin
               shift_in = write_data;
               phase_in = PH_WR_LOW;
               tick_in  = write_data[0] ? short_len : slot_len;
            end
            default: begin
               shift_in = '0;
               phase_in = PH_RD_LOW;
               tick_in  = short_len;
            end
         endcase
      end

      tick_dec = tick_in - LongTickWidth'(1);
      poll_inc = poll_in + ShortTickWidth'(1);

      if (phase_in != PH_IDLE) begin
         busy_res = 1'b1;
         case (phase_in)
            PH_RST_LOW: begin
               drive_low = 1'b1;
               tick_in   = tick_dec;
               if (tick_dec == '0) begin
                  phase_in = PH_RST_REL;
                  tick_in  = at_least_one_long(reset_release_ff);
               end
            end
            PH_RST_REL: begin
               tick_in = tick_dec;
               if (tick_dec == '0) begin
                  phase_in = PH_POLL_FALL;
                  poll_in  = '0;
               end
            end
            PH_POLL_FALL, PH_POLL_RISE: begin
               if (phase_in == PH_POLL_FALL && !line_level) begin
                  phase_in = PH_POLL_RISE;
                  poll_in  = '0;
               end else if (phase_in == PH_POLL_RISE && line_level) begin
                  done_res      = 1'b1;
                  presence_fail = fail_in;
                  phase_in      = PH_IDLE;
               end else begin
                  poll_in = poll_inc;
                  if (poll_inc >= at_least_one_short(poll_limit_ff)) begin
                     fail_in       = 1'b1;
                     done_res      = 1'b1;
                     presence_fail = 1'b1;
                     phase_in      = PH_IDLE;
                  end
               end
            end
            PH_WR_LOW: begin
               drive_low = 1'b1;
               tick_in   = tick_dec;
               if (tick_dec == '0) begin
                  phase_in = PH_WR_HIGH;
                  // A one bit gets the long recovery, a zero bit the short one.
                  tick_in  = shift_in[0] ? slot_len : short_len;
               end
            end
            PH_WR_HIGH: begin
               tick_in = tick_dec;
               if (tick_dec == '0) begin
                  shift_in = {1'b0, shift_in[ByteWidth-1:1]};
                  if (bit_in == 3'd7) begin
                     done_res = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PH_WR_LOW;
                     tick_in  = shift_in[0] ? short_len : slot_len;
                  end
               end
            end
            PH_RD_LOW: begin
               drive_low = 1'b1;
               tick_in   = tick_dec;
               if (tick_dec == '0) begin
                  phase_in = PH_RD_SETTLE;
                  tick_in  = short_len;
               end
            end
            PH_RD_SETTLE: begin
               tick_in = tick_dec;
               if (tick_dec == '0) begin
                  // The level of the last settle tick is the sampled bit.
                  shift_in = {line_level, shift_in[ByteWidth-1:1]};
                  phase_in = PH_RD_RECOVER;
                  tick_in  = at_least_one_long(read_recover_ff);
               end
            end
            PH_RD_RECOVER: begin
               tick_in = tick_dec;
               if (tick_dec == '0) begin
                  if (bit_in == 3'd7) begin
                     done_res = 1'b1;
                     rx_byte  = shift_in;
                     phase_in = PH_IDLE;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PH_RD_LOW;
                     tick_in  = short_len;
                  end
               end
            end
            default: begin
               // Codes that the sequencer never enters fall back to idle.
               phase_in = PH_IDLE;
               busy_res = 1'b0;
            end
         endcase
      end

      rsp_data_in = {4'b0000, rx_byte, presence_fail, done_res, busy_res, drive_low};
   end

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= RESET_LOW_DEFAULT;
         reset_release_ff <= RESET_RELEASE_DEFAULT;
         poll_limit_ff    <= POLL_LIMIT_DEFAULT;
         short_pulse_ff   <= SHORT_PULSE_DEFAULT;
         write_slot_ff    <= WRITE_SLOT_DEFAULT;
         read_recover_ff  <= READ_RECOVER_DEFAULT;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_RESET_LOW:     reset_low_ff     <= csr_wdata;
            CSR_RESET_RELEASE: reset_release_ff <= csr_wdata;
            CSR_POLL_LIMIT:    poll_limit_ff    <= csr_wdata[ShortTickWidth-1:0];
            CSR_SHORT_PULSE:   short_pulse_ff   <= csr_wdata[ShortTickWidth-1:0];
            CSR_WRITE_SLOT:    write_slot_ff    <= csr_wdata;
            CSR_READ_RECOVER:  read_recover_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Sequencer state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= '0;
         tick_ff  <= '0;
         poll_ff  <= '0;
         shift_ff <= '0;
         fail_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         poll_ff  <= poll_in;
         shift_ff <= shift_in;
         fail_ff  <= fail_in;
      end
   end

   // Response register: loaded on every accepted tick, emptied when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A completing command is always reported as busy in that tick.
   `OWBM_ASSERT_NOW(a_done_busy, clock, reset,
      rsp_valid_ff && rsp_data_ff[2], rsp_data_ff[1], "done without busy")
   // Presence failure and a read byte only come with done.
   `OWBM_ASSERT_NOW(a_fail_done, clock, reset,
      rsp_valid_ff && rsp_data_ff[3], rsp_data_ff[2], "presence failure without done")
   `OWBM_ASSERT_NOW(a_byte_done, clock, reset,
      rsp_valid_ff && rsp_data_ff[11:4] != '0, rsp_data_ff[2], "read byte without done")
   // After a completing tick the sequencer is idle again.
   `OWBM_ASSERT_NEXT(a_done_idle, clock, reset,
      req_accept && done_res, phase_ff == PH_IDLE, "sequencer not idle after done")

endmodule
